// ===== src/ptt_pkg.sv =====
// ----------------------------------------------------------------------------
// Periodic timer table package
// Shared types and codes for the timer table cells and their controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ptt_pkg;

  localparam int unsigned ID_W     = 32;
  localparam int unsigned IVL_W    = 32;
  localparam int unsigned MS_W     = 32;
  localparam int unsigned UNIX_W   = 40;
  localparam int unsigned UMS_W    = 48;
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned REQ_W    = 2;
  localparam int unsigned S_DATA_W = 192;
  localparam int unsigned M_DATA_W = 32;
  localparam int unsigned APB_AW   = 4;
  localparam int unsigned APB_DW   = 64;

  localparam logic [UNIX_W-1:0] WALL_MIN_RESET = 40'd1577836800;
  localparam logic [APB_AW-1:0] ADDR_WALL_MIN  = 4'h0;

  localparam logic [REQ_W-1:0] REQ_TICK     = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REGISTER = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CANCEL   = 2'd2;

  localparam logic [KIND_W-1:0] EV_REGISTERED = 3'd0;
  localparam logic [KIND_W-1:0] EV_FIRED      = 3'd1;
  localparam logic [KIND_W-1:0] EV_REJECTED   = 3'd2;
  localparam logic [KIND_W-1:0] EV_DUE        = 3'd3;
  localparam logic [KIND_W-1:0] EV_CANCELLED  = 3'd4;
  localparam logic [KIND_W-1:0] EV_MISS       = 3'd5;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [IVL_W-1:0]  interval;
    logic              once;
    logic              wall;
    logic [MS_W-1:0]   last_ms;
    logic [UNIX_W-1:0] last_unix;
    logic [UMS_W-1:0]  last_unix_ms;
  } slot_t;

  typedef struct packed {
    logic [MS_W-1:0]   nms;
    logic [UNIX_W-1:0] nu;
    logic [UMS_W-1:0]  nums;
    logic [UNIX_W-1:0] wall_min;
    logic              wall_ok;
  } now_t;

  typedef struct packed {
    logic load;
    logic shift;
    logic eval;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== src/ptt_cell.sv =====
// ----------------------------------------------------------------------------
// Timer table cell
// Holds one timer slot, tests it for expiry and takes its upper neighbour's
// slot when its own slot or a lower slot is removed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ptt_cell
  import ptt_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  input  cell_ctrl_t  ctrl,
  input  now_t        now,
  input  slot_t       load_slot,
  input  slot_t       up_slot,
  input  wire         up_valid,
  output slot_t       slot,
  output logic        valid,
  output logic        due
);

  logic             resync;
  logic [MS_W-1:0]  diff_ms;
  logic [UMS_W-1:0] diff_ums;
  logic             due_ms;
  logic             due_wall;

  always_comb begin
    resync   = slot.wall && now.wall_ok &&
               ((slot.last_unix < now.wall_min) || (now.nu < slot.last_unix));
    diff_ms  = now.nms - slot.last_ms;
    diff_ums = now.nums - slot.last_unix_ms;
    due_ms   = diff_ms >= slot.interval;
    due_wall = now.wall_ok && (now.nums != '0) && (slot.last_unix_ms != '0) &&
               (now.nums >= slot.last_unix_ms) &&
               (diff_ums >= {{(UMS_W-IVL_W){1'b0}}, slot.interval});
    due      = valid && !resync && (slot.wall ? due_wall : due_ms);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.load) begin
      valid <= 1'b1;
    end else if (ctrl.shift) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      slot <= load_slot;
    end else if (ctrl.shift) begin
      slot <= up_slot;
    end else if (ctrl.eval && valid) begin
      if (resync) begin
        slot.last_unix    <= now.nu;
        slot.last_unix_ms <= now.nums;
      end else if (due && !slot.once) begin
        slot.last_ms      <= now.nms;
        slot.last_unix    <= now.wall_ok ? now.nu : '0;
        slot.last_unix_ms <= now.wall_ok ? now.nums : '0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/periodic_timer_table_unit.sv =====
// ----------------------------------------------------------------------------
// Periodic timer table unit
// A row of timer cells in registration order with a sequencer for ticks,
// registrations and cancels.
// ----------------------------------------------------------------------------
// Requests arrive on the s_axis channel, with the request type in tuser and
// the operands and current clock readings in tdata. Results leave on m_axis:
// event kind in tuser, timer id in tdata, and tlast on the final word that a
// request causes. A tick with nothing due gives no word.
// Register and cancel requests give one word each. A cancel that hits then
// closes the gap in the row. A tick tests every slot in parallel in its accept
// cycle, then emits one due word per cycle while the receiver takes them,
// passes from emitting to removing, removes one fired one-shot slot per cycle
// and then returns to idle.
// A new request is taken only when the sequencer is idle and the output
// register is free; a stalled receiver holds the sequencer on its word.
// Reset empties the table, clears the id counter and restores wall_min.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module periodic_timer_table_unit
  import ptt_pkg::*;
#(
  parameter int unsigned SLOTS = 16
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 s_axis_tvalid,
  output logic                s_axis_tready,
  // interval_ms, run_once, wall_clock, execute_now, cancel_id, now_ms,
  // now_unix, now_unix_ms, zero fill
  input  wire  [S_DATA_W-1:0] s_axis_tdata,
  // req_type
  input  wire  [REQ_W-1:0]    s_axis_tuser,
  output logic                m_axis_tvalid,
  input  wire                 m_axis_tready,
  // task_id
  output logic [M_DATA_W-1:0] m_axis_tdata,
  // event_kind
  output logic [KIND_W-1:0]   m_axis_tuser,
  output logic                m_axis_tlast,
  input  wire                 psel,
  input  wire                 penable,
  input  wire                 pwrite,
  input  wire  [APB_AW-1:0]   paddr,
  input  wire  [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]   prdata,
  output logic                pready
);

  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef enum logic [1:0] {S_IDLE, S_EMIT, S_DROP} state_t;

  state_t            state;
  logic [ID_W-1:0]   next_id;
  logic [UNIX_W-1:0] wall_min;
  logic [SLOTS-1:0]  due_vec;
  logic [SLOTS-1:0]  drop_vec;

  cell_ctrl_t        cell_ctrl [SLOTS];
  slot_t             slots     [SLOTS];
  slot_t             up_slots  [SLOTS];
  logic [SLOTS-1:0]  valid_vec;
  logic [SLOTS-1:0]  up_valid;
  logic [SLOTS-1:0]  due_now;
  logic [SLOTS-1:0]  once_vec;
  logic [SLOTS-1:0]  match_vec;

  logic [IVL_W-1:0]  in_interval;
  logic              in_once;
  logic              in_wall;
  logic              in_exec;
  logic [ID_W-1:0]   in_cid;
  now_t              now;
  slot_t             new_slot;
  logic [REQ_W-1:0]  req;

  logic              accept;
  logic              out_free;
  logic              out_load;
  logic              full;
  logic              hit;
  logic [IDX_W-1:0]  free_idx;
  logic [IDX_W-1:0]  hit_idx;
  logic [IDX_W-1:0]  due_idx;
  logic [IDX_W-1:0]  drop_hi;
  logic [SLOTS-1:0]  due_rest;
  logic              cfg_wr;

  function automatic logic [IDX_W-1:0] lowest_set(input logic [SLOTS-1:0] v);
    logic [IDX_W-1:0] r;
    r = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (v[i]) r = IDX_W'(i);
    end
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] highest_set(input logic [SLOTS-1:0] v);
    logic [IDX_W-1:0] r;
    r = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (v[i]) r = IDX_W'(i);
    end
    return r;
  endfunction

  assign req         = s_axis_tuser;
  assign in_interval = s_axis_tdata[31:0];
  assign in_once     = s_axis_tdata[32];
  assign in_wall     = s_axis_tdata[33];
  assign in_exec     = s_axis_tdata[34];
  assign in_cid      = s_axis_tdata[66:35];

  always_comb begin
    now.nms      = s_axis_tdata[98:67];
    now.nu       = s_axis_tdata[138:99];
    now.nums     = s_axis_tdata[186:139];
    now.wall_min = wall_min;
    now.wall_ok  = s_axis_tdata[138:99] >= wall_min;

    new_slot.id           = next_id + 1'b1;
    new_slot.interval     = in_interval;
    new_slot.once         = in_once;
    new_slot.wall         = in_wall;
    new_slot.last_ms      = now.nms;
    new_slot.last_unix    = now.wall_ok ? now.nu : '0;
    new_slot.last_unix_ms = now.wall_ok ? now.nums : '0;
  end

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = (state == S_IDLE) && out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_load      = (accept && ((req == REQ_REGISTER) || (req == REQ_CANCEL))) ||
                         ((state == S_EMIT) && (due_vec != '0) && out_free);
  assign full          = &valid_vec;
  assign free_idx      = lowest_set(~valid_vec);
  assign hit           = |match_vec;
  assign hit_idx       = lowest_set(match_vec);
  assign due_idx       = lowest_set(due_vec);
  assign drop_hi       = highest_set(drop_vec);

  always_comb begin
    due_rest          = due_vec;
    due_rest[due_idx] = 1'b0;
  end

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      match_vec[i] = valid_vec[i] && (slots[i].id == in_cid) && (in_cid != '0);
      once_vec[i]  = slots[i].once;
      cell_ctrl[i].load  = accept && (req == REQ_REGISTER) && !full &&
                           (free_idx == IDX_W'(i));
      cell_ctrl[i].eval  = accept && (req == REQ_TICK);
      cell_ctrl[i].shift = (state == S_DROP) && (drop_vec != '0) &&
                           (IDX_W'(i) >= drop_hi);
    end
  end

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    if (g == SLOTS - 1) begin : g_top
      assign up_slots[g] = '0;
      assign up_valid[g] = 1'b0;
    end else begin : g_mid
      assign up_slots[g] = slots[g+1];
      assign up_valid[g] = valid_vec[g+1];
    end

    ptt_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (cell_ctrl[g]),
      .now       (now),
      .load_slot (new_slot),
      .up_slot   (up_slots[g]),
      .up_valid  (up_valid[g]),
      .slot      (slots[g]),
      .valid     (valid_vec[g]),
      .due       (due_now[g])
    );
  end

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_WALL_MIN);
  assign prdata = (paddr == ADDR_WALL_MIN) ?
                  {{(APB_DW-UNIX_W){1'b0}}, wall_min} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      next_id       <= '0;
      wall_min      <= WALL_MIN_RESET;
      due_vec       <= '0;
      drop_vec      <= '0;
      m_axis_tvalid <= 1'b0;
      m_axis_tdata  <= '0;
      m_axis_tuser  <= EV_REGISTERED;
      m_axis_tlast  <= 1'b0;
    end else begin
      if (cfg_wr) begin
        wall_min <= pwdata[UNIX_W-1:0];
      end
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            case (req)
              REQ_REGISTER: begin
                m_axis_tlast  <= 1'b1;
                if (full) begin
                  m_axis_tuser <= EV_REJECTED;
                  m_axis_tdata <= '0;
                end else begin
                  next_id      <= next_id + 1'b1;
                  m_axis_tuser <= in_exec ? EV_FIRED : EV_REGISTERED;
                  m_axis_tdata <= next_id + 1'b1;
                end
              end
              REQ_CANCEL: begin
                m_axis_tlast  <= 1'b1;
                m_axis_tdata  <= in_cid;
                m_axis_tuser  <= hit ? EV_CANCELLED : EV_MISS;
                if (hit) begin
                  drop_vec <= SLOTS'(1) << hit_idx;
                  state    <= S_DROP;
                end
              end
              REQ_TICK: begin
                due_vec  <= due_now;
                drop_vec <= due_now & once_vec;
                state    <= S_EMIT;
              end
              default: begin
              end
            endcase
          end
        end
        S_EMIT: begin
          if (due_vec == '0) begin
            state <= S_DROP;
          end else if (out_free) begin
            m_axis_tuser  <= EV_DUE;
            m_axis_tdata  <= slots[due_idx].id;
            m_axis_tlast  <= (due_rest == '0);
            due_vec       <= due_rest;
          end
        end
        S_DROP: begin
          if (drop_vec == '0) begin
            state <= S_IDLE;
          end else begin
            drop_vec[drop_hi] <= 1'b0;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_packed: assert property (@(posedge clk) disable iff (rst)
    ((({1'b0, valid_vec}) + 1'b1) & {1'b0, valid_vec}) == '0)
    else $error("timer slots are not packed at the low end");

  a_drop_valid: assert property (@(posedge clk) disable iff (rst)
    (state == S_DROP) |-> ((drop_vec & ~valid_vec) == '0))
    else $error("removal aimed at an empty slot");

  a_due_valid: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> ((due_vec & ~valid_vec) == '0))
    else $error("due word pending for an empty slot");

  a_id_step: assert property (@(posedge clk) disable iff (rst)
    (next_id != $past(next_id)) |-> (next_id == $past(next_id) + 1'b1))
    else $error("timer id counter moved by other than one");

endmodule

`default_nettype wire
